// ----- rtl/core/kar_pkg.sv -----
// Package for the key auto-repeat block: codes, widths and control structs.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package kar_pkg;

    // table geometry
    localparam int SLOT_COUNT  = 16;
    localparam int MAX_RESULTS = 16;
    localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // field widths
    localparam int ACT_W  = 2;
    localparam int KEY_W  = 8;
    localparam int KIND_W = 2;
    localparam int MS_W   = 16;
    localparam int CFG_W  = 16;
    localparam int CIDX_W = 1;

    // action codes
    localparam logic [ACT_W-1:0] ACT_TICK    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_PRESS   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd2;

    // event kinds
    localparam logic [KIND_W-1:0] KIND_DOWN   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UP     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REPEAT = 2'd2;

    // register indexes
    localparam logic [CIDX_W-1:0] CFG_FIRST  = 1'b0;
    localparam logic [CIDX_W-1:0] CFG_REPEAT = 1'b1;

    // register reset values
    localparam logic [CFG_W-1:0] FIRST_RST  = 16'd430;
    localparam logic [CFG_W-1:0] REPEAT_RST = 16'd85;

    localparam logic [MS_W-1:0] MS_MAX = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic step;
        logic flush;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic last_idx;
        logic emit_due;
        logic pend_valid;
        logic out_free;
    } t_stat;

endpackage

// ----- rtl/core/kar_in_if.sv -----
// Input channel of the key auto-repeat block: one action word per handshake.
// Depends on kar_pkg.
interface kar_in_if;
    logic                      valid;
    logic                      ready;
    logic [kar_pkg::ACT_W-1:0] action;
    logic [kar_pkg::KEY_W-1:0] key_code;

    modport source (output valid, output action, output key_code, input ready);
    modport sink   (input valid, input action, input key_code, output ready);
endinterface

// ----- rtl/core/kar_out_if.sv -----
// Output channel of the key auto-repeat block: one key event word per handshake.
// Depends on kar_pkg.
interface kar_out_if;
    logic                       valid;
    logic                       ready;
    logic [kar_pkg::KEY_W-1:0]  out_key;
    logic [kar_pkg::KIND_W-1:0] event_kind;
    logic                       last_of_run;

    modport source (output valid, output out_key, output event_kind,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_key, input event_kind,
                    input last_of_run, output ready);
endinterface

// ----- rtl/core/kar_ctrl.sv -----
// Controller of the key auto-repeat block: accept, slot scan, final flush.
// Depends on kar_pkg; drives the datapath kar_dp through kar_pkg::t_cmd.
module kar_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  kar_pkg::t_stat i_stat,
    output kar_pkg::t_cmd  o_cmd
);

    kar_pkg::t_state r_state;
    kar_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kar_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_cmd.start = 1'b0;
        o_cmd.step  = 1'b0;
        o_cmd.flush = 1'b0;
        case (r_state)
            kar_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = kar_pkg::ST_SCAN;
                end
            end
            kar_pkg::ST_SCAN: begin
                // hold the slot while a new repeat cannot push the held one out
                o_cmd.step = !(i_stat.emit_due && i_stat.pend_valid && !i_stat.out_free);
                if (o_cmd.step && i_stat.last_idx) begin
                    n_state = kar_pkg::ST_FLUSH;
                end
            end
            kar_pkg::ST_FLUSH: begin
                o_cmd.flush = 1'b1;
                if (!i_stat.pend_valid || i_stat.out_free) begin
                    n_state = kar_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = kar_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/kar_dp.sv -----
// Datapath of the key auto-repeat block: delay registers, slot table, scan
// index, held result and output register. Depends on kar_pkg; run by kar_ctrl.
module kar_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  kar_pkg::t_cmd               i_cmd,
    output kar_pkg::t_stat              o_stat,
    input  logic [kar_pkg::ACT_W-1:0]   i_action,
    input  logic [kar_pkg::KEY_W-1:0]   i_key_code,
    input  logic                        i_cfg_we,
    input  logic [kar_pkg::CIDX_W-1:0]  i_cfg_index,
    input  logic [kar_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [kar_pkg::KEY_W-1:0]   o_out_key,
    output logic [kar_pkg::KIND_W-1:0]  o_out_kind,
    output logic                        o_out_last
);

    // delay registers
    logic [kar_pkg::CFG_W-1:0] r_first;
    logic [kar_pkg::CFG_W-1:0] r_repeat;

    // slot table
    logic [kar_pkg::KEY_W-1:0] r_slot_key [kar_pkg::SLOT_COUNT];
    logic [kar_pkg::MS_W-1:0]  r_slot_el  [kar_pkg::SLOT_COUNT];
    logic                      r_slot_st  [kar_pkg::SLOT_COUNT];

    // word in progress
    logic [kar_pkg::SLOT_W-1:0] r_idx;
    logic [kar_pkg::ACT_W-1:0]  r_act;
    logic [kar_pkg::KEY_W-1:0]  r_key;
    logic                       r_done;
    logic [kar_pkg::CNT_W-1:0]  r_n;

    // held result, sent once the next one (or the end of the scan) is known
    logic                        r_pend_valid;
    logic [kar_pkg::KEY_W-1:0]   r_pend_key;
    logic [kar_pkg::KIND_W-1:0]  r_pend_kind;

    logic                        r_out_valid;
    logic [kar_pkg::KEY_W-1:0]   r_out_key;
    logic [kar_pkg::KIND_W-1:0]  r_out_kind;
    logic                        r_out_last;

    logic [kar_pkg::KEY_W-1:0] cur_key;
    logic [kar_pkg::MS_W-1:0]  cur_el;
    logic                      cur_st;
    logic [kar_pkg::MS_W-1:0]  d1;
    logic [kar_pkg::MS_W-1:0]  d2;
    logic [kar_pkg::MS_W-1:0]  el_inc;
    logic [kar_pkg::MS_W-1:0]  use_ms;
    logic                      is_tick;
    logic                      is_press;
    logic                      is_release;
    logic                      room;
    logic                      emit_due;
    logic                      out_free;
    logic                      push_mid;
    logic                      push_end;

    // slot under the scan index
    always_comb begin
        cur_key    = r_slot_key[r_idx];
        cur_el     = r_slot_el[r_idx];
        cur_st     = r_slot_st[r_idx];
        d1         = (r_first == '0) ? kar_pkg::MS_W'(1) : r_first;
        d2         = (r_repeat == '0) ? kar_pkg::MS_W'(1) : r_repeat;
        el_inc     = (cur_el != kar_pkg::MS_MAX) ? cur_el + kar_pkg::MS_W'(1) : cur_el;
        is_tick    = (r_act == kar_pkg::ACT_TICK);
        is_press   = (r_act == kar_pkg::ACT_PRESS);
        is_release = (r_act == kar_pkg::ACT_RELEASE);
        room       = (r_n < kar_pkg::CNT_W'(kar_pkg::MAX_RESULTS));
        use_ms     = cur_st ? d2 : d1;
        emit_due   = is_tick && (cur_key != '0) && room && (el_inc >= use_ms);
        out_free   = !r_out_valid || i_out_ready;
        push_mid   = i_cmd.step && emit_due && r_pend_valid;
        push_end   = i_cmd.flush && r_pend_valid && out_free;
    end

    assign o_stat.last_idx   = (r_idx == kar_pkg::SLOT_W'(kar_pkg::SLOT_COUNT - 1));
    assign o_stat.emit_due   = emit_due;
    assign o_stat.pend_valid = r_pend_valid;
    assign o_stat.out_free   = out_free;

    // control state: delays, slot keys, held and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first      <= kar_pkg::FIRST_RST;
            r_repeat     <= kar_pkg::REPEAT_RST;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int s = 0; s < kar_pkg::SLOT_COUNT; s++) begin
                r_slot_key[s] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    kar_pkg::CFG_FIRST:  r_first  <= i_cfg_data;
                    kar_pkg::CFG_REPEAT: r_repeat <= i_cfg_data;
                    default: ;
                endcase
            end

            if (i_cmd.start) begin
                r_pend_valid <= (i_action == kar_pkg::ACT_PRESS) ||
                                (i_action == kar_pkg::ACT_RELEASE);
            end else if (i_cmd.step && emit_due) begin
                r_pend_valid <= 1'b1;
            end else if (push_end) begin
                r_pend_valid <= 1'b0;
            end

            // press claims the first free slot, release frees matches
            if (i_cmd.step) begin
                if (is_press && !r_done && (r_key != '0) && (cur_key == '0)) begin
                    r_slot_key[r_idx] <= r_key;
                end else if (is_release && (cur_key == r_key)) begin
                    r_slot_key[r_idx] <= '0;
                end
            end

            if (push_mid || push_end) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: scan state, slot timers, held and output words
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_act       <= i_action;
            r_key       <= i_key_code;
            r_idx       <= '0;
            r_done      <= 1'b0;
            r_n         <= '0;
            r_pend_key  <= i_key_code;
            r_pend_kind <= (i_action == kar_pkg::ACT_RELEASE) ? kar_pkg::KIND_UP
                                                               : kar_pkg::KIND_DOWN;
        end
        if (i_cmd.step) begin
            r_idx <= r_idx + kar_pkg::SLOT_W'(1);
            if (is_press && !r_done && (r_key != '0) && (cur_key == '0)) begin
                r_done            <= 1'b1;
                r_slot_el[r_idx]  <= '0;
                r_slot_st[r_idx]  <= 1'b0;
            end
            if (is_tick && (cur_key != '0)) begin
                r_slot_el[r_idx] <= emit_due ? el_inc - use_ms : el_inc;
            end
            if (emit_due) begin
                r_slot_st[r_idx] <= 1'b1;
                r_n              <= r_n + kar_pkg::CNT_W'(1);
                r_pend_key       <= cur_key;
                r_pend_kind      <= kar_pkg::KIND_REPEAT;
            end
        end
        if (push_mid || push_end) begin
            r_out_key  <= r_pend_key;
            r_out_kind <= r_pend_kind;
            r_out_last <= push_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_key   = r_out_key;
    assign o_out_kind  = r_out_kind;
    assign o_out_last  = r_out_last;

endmodule

// ----- rtl/core/key_auto_repeat.sv -----
// Top level of the key auto-repeat block: joins controller and datapath.
// Depends on kar_pkg, kar_in_if, kar_out_if, kar_ctrl and kar_dp.
//
//   channel  dir  word                               handshake
//   i_key    in   action, key_code                   valid/ready
//   o_evt    out  out_key, event_kind, last_of_run   valid/ready
//   i_cfg_*  in   index, data (16 bit)               write enable only
//
// Each word passes through an accept state, a sequential scan over every slot
// (SLOT_COUNT = 16) and a flush state that sends any held result.
// A stalled output holds the scan while a new repeat waits.
// Reset is synchronous, active low; it clears all slots at once.
// Up to one result leaves per cycle through the registered output, while o_evt.ready is high.
module key_auto_repeat (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    kar_in_if.sink                      i_key,
    kar_out_if.source                   o_evt,
    input  logic                        i_cfg_we,
    input  logic [kar_pkg::CIDX_W-1:0]  i_cfg_index,
    input  logic [kar_pkg::CFG_W-1:0]   i_cfg_data
);

    kar_pkg::t_cmd  cmd;
    kar_pkg::t_stat stat;

    kar_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_key.valid),
        .o_in_ready (i_key.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    kar_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_action    (i_key.action),
        .i_key_code  (i_key.key_code),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (o_evt.ready),
        .o_out_valid (o_evt.valid),
        .o_out_key   (o_evt.out_key),
        .o_out_kind  (o_evt.event_kind),
        .o_out_last  (o_evt.last_of_run)
    );

    // no word is taken while a result is still held back
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_key.ready |-> !stat.pend_valid)
        else $error("input ready while a result is held");

    // an accepted word keeps the block busy for the scan
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_key.valid && i_key.ready) |=> !i_key.ready)
        else $error("input ready right after accept");

    // down and up events are always the only result of their word
    a_echo_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_evt.valid && (o_evt.event_kind != kar_pkg::KIND_REPEAT)) |-> o_evt.last_of_run)
        else $error("key down or up event not marked last");

endmodule

// ----- tb/tb_key_auto_repeat.sv -----
// Self-checking testbench for key_auto_repeat: directed and random key words, scoreboard check.
// Depends on kar_pkg, kar_in_if, kar_out_if and the key_auto_repeat RTL.
// A typematic table model in the scoreboard predicts every key event word.
module tb_key_auto_repeat;

    // action code that the block must ignore
    localparam logic [kar_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;

    localparam int DRAIN_CYCLES   = 40;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef struct packed {
        logic [kar_pkg::KEY_W-1:0]  key;
        logic [kar_pkg::KIND_W-1:0] kind;
        logic                       last;
    } t_key_event;

    // table model plus queue of key events still to come
    class typematic_board;
        logic [kar_pkg::CFG_W-1:0] first_ms  = kar_pkg::FIRST_RST;
        logic [kar_pkg::CFG_W-1:0] rep_ms    = kar_pkg::REPEAT_RST;
        logic [kar_pkg::KEY_W-1:0] slot_code [kar_pkg::SLOT_COUNT];
        logic [kar_pkg::MS_W-1:0]  slot_ms   [kar_pkg::SLOT_COUNT];
        bit                        slot_run  [kar_pkg::SLOT_COUNT];
        t_key_event                due_events [$];
        int                        errors       = 0;
        int                        words_in     = 0;
        int                        events_out   = 0;
        int                        repeats_seen = 0;

        function new();
            foreach (slot_code[i]) begin
                slot_code[i] = '0;
                slot_ms[i]   = '0;
                slot_run[i]  = 1'b0;
            end
        endfunction

        function void write_reg(logic [kar_pkg::CIDX_W-1:0] idx,
                                logic [kar_pkg::CFG_W-1:0] value);
            if (idx == kar_pkg::CFG_FIRST)
                first_ms = value;
            else
                rep_ms = value;
        endfunction

        function void push_event(logic [kar_pkg::KEY_W-1:0] key,
                                 logic [kar_pkg::KIND_W-1:0] kind, bit last);
            t_key_event ev;
            ev.key  = key;
            ev.kind = kind;
            ev.last = last;
            due_events.push_back(ev);
        endfunction

        // predict the events caused by one accepted word
        function void note_word(logic [kar_pkg::ACT_W-1:0] act,
                                logic [kar_pkg::KEY_W-1:0] code);
            int d1;
            int d2;
            int e;
            int spent;
            int n;
            t_key_event tail;
            n = 0;
            d1 = (first_ms == 0) ? 1 : int'(first_ms);
            d2 = (rep_ms == 0) ? 1 : int'(rep_ms);
            words_in++;
            case (act)
                kar_pkg::ACT_PRESS: begin
                    // key code zero is echoed but never tracked
                    if (code != 0) begin
                        for (int i = 0; i < kar_pkg::SLOT_COUNT; i++) begin
                            if (slot_code[i] == 0) begin
                                slot_code[i] = code;
                                slot_ms[i]   = '0;
                                slot_run[i]  = 1'b0;
                                break;
                            end
                        end
                    end
                    push_event(code, kar_pkg::KIND_DOWN, 1'b1);
                end
                kar_pkg::ACT_RELEASE: begin
                    // frees every slot holding the code
                    foreach (slot_code[i])
                        if (slot_code[i] == code)
                            slot_code[i] = '0;
                    push_event(code, kar_pkg::KIND_UP, 1'b1);
                end
                kar_pkg::ACT_TICK: begin
                    for (int i = 0; i < kar_pkg::SLOT_COUNT; i++) begin
                        if (slot_code[i] == 0)
                            continue;
                        e = int'(slot_ms[i]);
                        if (e < int'(kar_pkg::MS_MAX))
                            e++;
                        spent = 0;
                        if (n < kar_pkg::MAX_RESULTS) begin
                            if (!slot_run[i]) begin
                                if (e >= d1)
                                    spent = d1;
                            end else if (e >= d2) begin
                                spent = d2;
                            end
                        end
                        if (spent != 0) begin
                            e -= spent;
                            slot_run[i] = 1'b1;
                            push_event(slot_code[i], kar_pkg::KIND_REPEAT, 1'b0);
                            n++;
                        end
                        slot_ms[i] = e[kar_pkg::MS_W-1:0];
                    end
                    // mark the final repeat of this tick
                    if (n > 0) begin
                        tail = due_events.pop_back();
                        tail.last = 1'b1;
                        due_events.push_back(tail);
                    end
                end
                default: begin
                    // unused action: nothing happens
                end
            endcase
        endfunction

        function void check_event(logic [kar_pkg::KEY_W-1:0] key,
                                  logic [kar_pkg::KIND_W-1:0] kind, logic last);
            t_key_event want;
            events_out++;
            if (kind == kar_pkg::KIND_REPEAT)
                repeats_seen++;
            if (due_events.size() == 0) begin
                $display("%0t: unexpected event key=%0h kind=%0d last=%0b",
                         $time, key, kind, last);
                errors++;
                return;
            end
            want = due_events.pop_front();
            if (key !== want.key) begin
                $display("%0t: out_key expected %0h actual %0h", $time, want.key, key);
                errors++;
            end
            if (kind !== want.kind) begin
                $display("%0t: event_kind expected %0d actual %0d",
                         $time, want.kind, kind);
                errors++;
            end
            if (last !== want.last) begin
                $display("%0t: last_of_run expected %0b actual %0b",
                         $time, want.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return due_events.size();
        endfunction

        // a key currently held, so that releases mostly hit the table
        function logic [kar_pkg::KEY_W-1:0] pick_held();
            logic [kar_pkg::KEY_W-1:0] held [$];
            foreach (slot_code[i])
                if (slot_code[i] != 0)
                    held.push_back(slot_code[i]);
            if (held.size() == 0)
                return kar_pkg::KEY_W'($urandom_range(1, 255));
            return held[$urandom_range(0, held.size() - 1)];
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic                       cfg_we;
    logic [kar_pkg::CIDX_W-1:0] cfg_index;
    logic [kar_pkg::CFG_W-1:0]  cfg_data;

    kar_in_if  key_ch ();
    kar_out_if evt_ch ();

    typematic_board board = new();

    bit quiet          = 1'b0;
    bit long_hold_req  = 1'b0;
    bit long_hold_done = 1'b0;
    int idle_cycles    = 0;
    int settings_used  = 0;

    logic [kar_pkg::KEY_W-1:0] key_pool [8] = '{8'h01, 8'h1C, 8'h2A, 8'h39,
                                                8'h48, 8'h80, 8'hC3, 8'hFE};

    key_auto_repeat dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key       (key_ch),
        .o_evt       (evt_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // monitor both channels, watchdog on accepted words
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (key_ch.valid && key_ch.ready)
                board.note_word(key_ch.action, key_ch.key_code);
            if (evt_ch.valid && evt_ch.ready)
                board.check_event(evt_ch.out_key, evt_ch.event_kind, evt_ch.last_of_run);
            if ((key_ch.valid && key_ch.ready) || (evt_ch.valid && evt_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no word accepted for %0d cycles", $time, idle_cycles);
                $display("FAIL key_auto_repeat");
                $finish;
            end
        end
    end

    // event sink: random stalls, one long hold on request
    initial begin : event_sink
        int stall;
        evt_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (long_hold_req && !long_hold_done) begin
                long_hold_done = 1'b1;
                evt_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                stall = quiet ? 0 : $urandom_range(0, 16);
                if (stall > 0) begin
                    evt_ch.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            evt_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!evt_ch.valid)
                @(posedge i_clk);
        end
    end

    // offer one word, return at the edge that accepts it
    task automatic send_word(input logic [kar_pkg::ACT_W-1:0] act,
                             input logic [kar_pkg::KEY_W-1:0] code);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            key_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        key_ch.valid    <= 1'b1;
        key_ch.action   <= act;
        key_ch.key_code <= code;
        @(posedge i_clk);
        while (!key_ch.ready)
            @(posedge i_clk);
    endtask

    // stop offering until every predicted event is out and the scan is done
    task automatic settle_idle();
        key_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [kar_pkg::CIDX_W-1:0] idx,
                           input logic [kar_pkg::CFG_W-1:0] value);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        board.write_reg(idx, value);
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // one delay setting followed by a run of random words
    task automatic run_phase(input int unsigned first_ms, input int unsigned rep_ms,
                             input int words, input bit calm, input bit hold);
        logic [kar_pkg::ACT_W-1:0] act;
        logic [kar_pkg::KEY_W-1:0] code;
        int sent;
        int r;
        settle_idle();
        set_reg(kar_pkg::CFG_FIRST, kar_pkg::CFG_W'(first_ms));
        set_reg(kar_pkg::CFG_REPEAT, kar_pkg::CFG_W'(rep_ms));
        settings_used++;
        quiet = calm;
        long_hold_req = hold;
        sent = 0;
        while (sent < words) begin
            r = $urandom_range(0, 99);
            code = kar_pkg::KEY_W'($urandom);
            if (r < 55) begin
                act = kar_pkg::ACT_TICK;
            end else if (r < 75) begin
                act = kar_pkg::ACT_PRESS;
                if ($urandom_range(0, 7) != 0)
                    code = key_pool[$urandom_range(0, 7)];
            end else if (r < 94) begin
                act = kar_pkg::ACT_RELEASE;
                if ($urandom_range(0, 5) != 0)
                    code = board.pick_held();
            end else begin
                act = ACT_UNUSED;
            end
            send_word(act, code);
            if (act != ACT_UNUSED)
                sent++;
        end
    endtask

    initial begin : stimulus
        key_ch.valid    <= 1'b0;
        key_ch.action   <= kar_pkg::ACT_TICK;
        key_ch.key_code <= '0;
        cfg_we          <= 1'b0;
        cfg_index       <= kar_pkg::CFG_FIRST;
        cfg_data        <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset delays: untracked zero key, stray release, ignored code, doubled key
        send_word(kar_pkg::ACT_PRESS, 8'h00);
        send_word(kar_pkg::ACT_PRESS, 8'hFF);
        send_word(kar_pkg::ACT_RELEASE, 8'h07);
        send_word(kar_pkg::ACT_TICK, 8'h00);
        send_word(ACT_UNUSED, 8'hA5);
        send_word(kar_pkg::ACT_PRESS, 8'h42);
        send_word(kar_pkg::ACT_PRESS, 8'h42);
        send_word(kar_pkg::ACT_TICK, 8'hFF);
        send_word(kar_pkg::ACT_RELEASE, 8'h42);

        // shortest delays: fill the table, one press too many, full tick
        settle_idle();
        set_reg(kar_pkg::CFG_FIRST, kar_pkg::CFG_W'(1));
        set_reg(kar_pkg::CFG_REPEAT, kar_pkg::CFG_W'(1));
        settings_used++;
        for (int i = 0; i < 16; i++)
            send_word(kar_pkg::ACT_PRESS, kar_pkg::KEY_W'(8'h10 + i));
        send_word(kar_pkg::ACT_TICK, 8'h5A);

        // random phases; long stall first, high delays then low to drain backlog
        run_phase(1, 1, 20, 1'b1, 1'b1);
        run_phase(3, 2, 20, 1'b0, 1'b0);
        run_phase(65535, 65535, 20, 1'b0, 1'b0);
        run_phase(1, 1, 15, 1'b0, 1'b0);
        run_phase($urandom_range(1, 12), $urandom_range(1, 8), 20, 1'b1, 1'b0);
        run_phase(1, 65535, 15, 1'b0, 1'b0);
        run_phase(65535, 1, 10, 1'b0, 1'b0);
        run_phase($urandom_range(1, 6), $urandom_range(1, 4), 15, 1'b0, 1'b0);
        settle_idle();

        $display("Covered %0d key words under %0d delay settings.",
                 board.words_in, settings_used);
        $display("Checked %0d key events, %0d of them auto repeats, %0d mismatches.",
                 board.events_out, board.repeats_seen, board.errors);
        if (board.errors == 0) begin
            $display("PASS key_auto_repeat");
        end else begin
            $display("FAIL key_auto_repeat");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/core/kar_pkg.sv
rtl/core/kar_in_if.sv
rtl/core/kar_out_if.sv
rtl/core/kar_ctrl.sv
rtl/core/kar_dp.sv
rtl/core/key_auto_repeat.sv
tb/tb_key_auto_repeat.sv
